// ===== hdl/palette_quantizer_with_dither_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the palette quantizer checker
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PALETTE_QUANTIZER_WITH_DITHER_ASSERT_SVH
`define PALETTE_QUANTIZER_WITH_DITHER_ASSERT_SVH

// Check a property on every rising edge outside reset
`define PQD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define PQD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pqd_pkg.sv =====
// ----------------------------------------------------------------------------
// pqd_pkg
// Shared types, constants and helper functions of the palette quantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pqd_pkg;

    // Palette store geometry
    localparam int PALETTE_SIZE = 256;
    localparam int STORE_DEPTH  = 256;
    localparam int ADDR_W       = 8;
    localparam int COLOR_W      = 24;
    localparam int CHAN_W       = 8;
    localparam int SCORE_W      = 8;

    // Item commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Random generator
    localparam logic [31:0] GEN_MUL  = 32'd16807;
    localparam logic [31:0] GEN_SEED = 32'd1234567;

    // Fixed-point scale of the dither compare
    localparam int SCALE    = 1000;
    localparam int RAND_W   = 10;
    localparam int PROD_W   = 41;
    localparam int CHANCE_W = 10;

    // Divider for the chance value
    localparam int DIV_NUM_W = 18;
    localparam int DIV_CNT_W = 5;

    // Score is the channel sum divided by three, done by reciprocal
    localparam int SCORE_RECIP = 683;
    localparam int SCORE_SHIFT = 11;

    // Configuration port
    localparam int          CFG_ADDR_W      = 3;
    localparam int          CFG_IDX_W       = 1;
    localparam logic [0:0]  CFG_IDX_DITHER  = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_GEN,
        ST_RAND,
        ST_ROUND,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [SCORE_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [CHANCE_W-1:0] quot;
    } div_rsp_t;

    // Score of one palette color against a pixel
    function automatic logic [SCORE_W-1:0] color_score(
        input logic [COLOR_W-1:0] color,
        input logic [CHAN_W-1:0]  r,
        input logic [CHAN_W-1:0]  g,
        input logic [CHAN_W-1:0]  b
    );
        logic [CHAN_W-1:0] cr;
        logic [CHAN_W-1:0] cg;
        logic [CHAN_W-1:0] cb;
        logic [CHAN_W-1:0] dr;
        logic [CHAN_W-1:0] dg;
        logic [CHAN_W-1:0] db;
        logic [9:0]        sum;
        logic [19:0]       prod;
        cr   = color[23:16];
        cg   = color[15:8];
        cb   = color[7:0];
        dr   = (cr > r) ? (cr - r) : (r - cr);
        dg   = (cg > g) ? (cg - g) : (g - cg);
        db   = (cb > b) ? (cb - b) : (b - cb);
        sum  = 10'(dr) + 10'(dg) + 10'(db);
        prod = 20'(sum) * 20'(SCORE_RECIP);
        return prod[SCORE_SHIFT+SCORE_W-1:SCORE_SHIFT];
    endfunction

endpackage

// ===== hdl/pqd_if.sv =====
// ----------------------------------------------------------------------------
// pqd_if
// Valid/ready channels of the palette quantizer: input items and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pqd_item_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [pqd_pkg::ADDR_W-1:0]    entry_index;
    logic [pqd_pkg::COLOR_W-1:0]   entry_color;
    logic [pqd_pkg::CHAN_W-1:0]    red;
    logic [pqd_pkg::CHAN_W-1:0]    green;
    logic [pqd_pkg::CHAN_W-1:0]    blue;
    logic                          frame_start;

    modport source (
        output valid, cmd, entry_index, entry_color, red, green, blue, frame_start,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, entry_color, red, green, blue, frame_start,
        output ready
    );
endinterface

interface pqd_result_if;
    logic                       valid;
    logic                       ready;
    logic [pqd_pkg::ADDR_W-1:0] pixel_index;

    modport source (
        output valid, pixel_index,
        input  ready
    );
    modport sink (
        input  valid, pixel_index,
        output ready
    );
endinterface

// ===== hdl/pqd_ram.sv =====
// ----------------------------------------------------------------------------
// pqd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pqd_ram #(
    parameter int WIDTH = pqd_pkg::COLOR_W,
    parameter int DEPTH = pqd_pkg::STORE_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/pqd_div.sv =====
// ----------------------------------------------------------------------------
// pqd_div
// Restoring divider, one quotient bit per cycle, result rounded half to even.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pqd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pqd_pkg::div_req_t req,
    output pqd_pkg::div_rsp_t rsp
);

    localparam int NW = pqd_pkg::DIV_NUM_W;
    localparam int DW = pqd_pkg::SCORE_W;
    localparam int CW = pqd_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] num_next;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] den_next;

    logic [DW:0]   trial;
    logic          fits;
    logic [DW:0]   rem_twice;
    logic          round_up;
    logic [NW-1:0] quot_rounded;

    // Shift in one numerator bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg, num_reg[NW-1]};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Advance the division
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CW'(NW);
            num_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NW-2:0], fits};
            rem_next = fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // Round the finished quotient half to even
    always_comb
    begin
        rem_twice    = {rem_reg, 1'b0};
        round_up     = (rem_twice > {1'b0, den_reg})
                    || ((rem_twice == {1'b0, den_reg}) && num_reg[0]);
        quot_rounded = num_reg + NW'(round_up);
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_rounded[pqd_pkg::CHANCE_W-1:0];

endmodule

// ===== hdl/palette_quantizer_with_dither.sv =====
// ----------------------------------------------------------------------------
// palette_quantizer_with_dither
// Nearest palette color search with optional random dither to the runner-up.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  item    | in        | valid/ready          | cmd, entry_index, entry_color,
//          |           |                      | red, green, blue, frame_start
//  result  | out       | valid/ready          | pixel_index
//  apb     | in        | psel/penable/pready  | paddr, pwdata, prdata
//
//  A load item writes the palette RAM in its accept cycle. A pixel item
//  scans the palette, reading one palette entry per cycle from the RAM port;
//  with dither on, the generator, the scale multiply and the bit-serial
//  divider follow (the divider is skipped when the runner-up scores zero).
//  Reset is asynchronous and needs no clearing pass; palette entries are
//  undefined until loaded. A waiting result stalls only the next pixel's end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_quantizer_with_dither #(
    parameter int PALETTE_SIZE = pqd_pkg::PALETTE_SIZE
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pqd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    pqd_item_if.sink                         item,
    pqd_result_if.source                     result
);

    localparam int AW = pqd_pkg::ADDR_W;
    localparam int SW = pqd_pkg::SCORE_W;
    localparam int CHW = pqd_pkg::CHAN_W;
    localparam int PW = pqd_pkg::PROD_W;
    localparam int RW = pqd_pkg::RAND_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(PALETTE_SIZE - 1);

    pqd_pkg::state_t state_reg;
    pqd_pkg::state_t state_next;

    logic            dither_reg;
    logic            dither_next;
    logic [31:0]     gen_reg;
    logic [31:0]     gen_next;
    logic [AW-1:0]   cnt_reg;
    logic [AW-1:0]   cnt_next;
    logic            cmp_valid_reg;
    logic            cmp_valid_next;
    logic [AW-1:0]   cmp_idx_reg;
    logic [AW-1:0]   cmp_idx_next;
    logic [CHW-1:0]  red_reg;
    logic [CHW-1:0]  red_next;
    logic [CHW-1:0]  green_reg;
    logic [CHW-1:0]  green_next;
    logic [CHW-1:0]  blue_reg;
    logic [CHW-1:0]  blue_next;
    logic [SW-1:0]   best_reg;
    logic [SW-1:0]   best_next;
    logic [SW-1:0]   rscore_reg;
    logic [SW-1:0]   rscore_next;
    logic [AW-1:0]   nearest_reg;
    logic [AW-1:0]   nearest_next;
    logic [AW-1:0]   runner_reg;
    logic [AW-1:0]   runner_next;
    logic [PW-1:0]   prod_reg;
    logic [PW-1:0]   prod_next;
    logic [RW-1:0]   randf_reg;
    logic [RW-1:0]   randf_next;
    logic            sel_runner_reg;
    logic            sel_runner_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [AW-1:0]   out_index_reg;
    logic [AW-1:0]   out_index_next;

    logic                        in_accept;
    logic                        out_free;
    logic                        cfg_write;
    logic                        mem_wr_en;
    logic                        mem_rd_en;
    logic [AW-1:0]               mem_rd_addr;
    logic [pqd_pkg::COLOR_W-1:0] mem_rd_data;
    logic [SW-1:0]               score_cur;
    logic [31:0]                 mag;
    logic [RW-1:0]               rand_q;
    logic [30:0]                 rand_r;
    logic                        rand_up;
    logic [SW-1:0]               score_gap;
    pqd_pkg::div_req_t           div_req;
    pqd_pkg::div_rsp_t           div_rsp;

    // Handshake decode
    assign item.ready = (state_reg == pqd_pkg::ST_IDLE);
    assign in_accept  = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[pqd_pkg::CFG_ADDR_W-1:2] == pqd_pkg::CFG_IDX_DITHER)
                     ? {31'd0, dither_reg} : 32'd0;

    always_comb
    begin
        dither_next = dither_reg;
        if (cfg_write && (paddr[pqd_pkg::CFG_ADDR_W-1:2] == pqd_pkg::CFG_IDX_DITHER))
        begin
            dither_next = pwdata[0];
        end
    end

    // Palette store
    pqd_ram #(
        .WIDTH (pqd_pkg::COLOR_W),
        .DEPTH (pqd_pkg::STORE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (item.entry_index),
        .wr_data (item.entry_color),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Chance divider
    pqd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pqd_pkg::ST_IDLE:
            begin
                if (in_accept && (item.cmd == pqd_pkg::CMD_PIXEL))
                begin
                    state_next = pqd_pkg::ST_SCAN;
                end
            end
            pqd_pkg::ST_SCAN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = pqd_pkg::ST_DRAIN;
                end
            end
            pqd_pkg::ST_DRAIN:
            begin
                state_next = dither_reg ? pqd_pkg::ST_GEN : pqd_pkg::ST_FINISH;
            end
            pqd_pkg::ST_GEN:   state_next = pqd_pkg::ST_RAND;
            pqd_pkg::ST_RAND:  state_next = pqd_pkg::ST_ROUND;
            pqd_pkg::ST_ROUND: state_next = pqd_pkg::ST_WAIT;
            pqd_pkg::ST_WAIT:
            begin
                if ((rscore_reg == '0) || div_rsp.done)
                begin
                    state_next = pqd_pkg::ST_FINISH;
                end
            end
            pqd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = pqd_pkg::ST_IDLE;
                end
            end
            default: state_next = pqd_pkg::ST_IDLE;
        endcase
    end

    // Memory and divider controls
    always_comb
    begin
        mem_wr_en     = in_accept && (item.cmd == pqd_pkg::CMD_LOAD);
        mem_rd_en     = (state_reg == pqd_pkg::ST_SCAN);
        mem_rd_addr   = cnt_reg;
        score_gap     = (rscore_reg >= best_reg) ? (rscore_reg - best_reg) : '0;
        div_req.start = (state_reg == pqd_pkg::ST_GEN) && (rscore_reg != '0);
        div_req.num   = pqd_pkg::DIV_NUM_W'(score_gap)
                      * pqd_pkg::DIV_NUM_W'(pqd_pkg::SCALE);
        div_req.den   = rscore_reg;
    end

    // Score of the entry read last cycle
    assign score_cur = pqd_pkg::color_score(mem_rd_data, red_reg, green_reg, blue_reg);

    // Magnitude of the generator value and its rounded scale
    always_comb
    begin
        mag     = gen_reg[31] ? (~gen_reg + 32'd1) : gen_reg;
        rand_q  = prod_reg[RW+30:31];
        rand_r  = prod_reg[30:0];
        rand_up = (rand_r[30] && (rand_r[29:0] != '0))
               || ((rand_r == {1'b1, 30'd0}) && rand_q[0]);
    end

    // Datapath next values
    always_comb
    begin
        gen_next        = gen_reg;
        cnt_next        = cnt_reg;
        cmp_valid_next  = (state_reg == pqd_pkg::ST_SCAN);
        cmp_idx_next    = cnt_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        best_next       = best_reg;
        rscore_next     = rscore_reg;
        nearest_next    = nearest_reg;
        runner_next     = runner_reg;
        prod_next       = prod_reg;
        randf_next      = randf_reg;
        sel_runner_next = sel_runner_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_index_next  = out_index_reg;

        // Capture a pixel item and reseed on frame start
        if (in_accept && (item.cmd == pqd_pkg::CMD_PIXEL))
        begin
            red_next        = item.red;
            green_next      = item.green;
            blue_next       = item.blue;
            cnt_next        = '0;
            sel_runner_next = 1'b0;
            if (item.frame_start)
            begin
                gen_next = pqd_pkg::GEN_SEED;
            end
        end

        // Advance the read address through the palette
        if (state_reg == pqd_pkg::ST_SCAN)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        // Keep nearest and runner-up; entry zero seeds both
        if (cmp_valid_reg)
        begin
            if (cmp_idx_reg == '0)
            begin
                nearest_next = '0;
                runner_next  = '0;
                best_next    = score_cur;
                rscore_next  = score_cur;
            end
            else if (score_cur < best_reg)
            begin
                runner_next  = nearest_reg;
                rscore_next  = best_reg;
                nearest_next = cmp_idx_reg;
                best_next    = score_cur;
            end
        end

        case (state_reg)
            pqd_pkg::ST_GEN:
            begin
                gen_next = 32'(gen_reg * pqd_pkg::GEN_MUL);
            end
            pqd_pkg::ST_RAND:
            begin
                prod_next = PW'(mag) * PW'(pqd_pkg::SCALE);
            end
            pqd_pkg::ST_ROUND:
            begin
                randf_next = rand_q + RW'(rand_up);
            end
            pqd_pkg::ST_WAIT:
            begin
                if ((rscore_reg != '0) && div_rsp.done)
                begin
                    sel_runner_next = (randf_reg > div_rsp.quot);
                end
            end
            pqd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = sel_runner_reg ? runner_reg : nearest_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pqd_pkg::ST_IDLE;
            dither_reg    <= 1'b0;
            gen_reg       <= pqd_pkg::GEN_SEED;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dither_reg    <= dither_next;
            gen_reg       <= gen_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        red_reg        <= red_next;
        green_reg      <= green_next;
        blue_reg       <= blue_next;
        best_reg       <= best_next;
        rscore_reg     <= rscore_next;
        nearest_reg    <= nearest_next;
        runner_reg     <= runner_next;
        prod_reg       <= prod_next;
        randf_reg      <= randf_next;
        sel_runner_reg <= sel_runner_next;
        out_index_reg  <= out_index_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.pixel_index = out_index_reg;

endmodule

// ===== hdl/pqd_checker.sv =====
// ----------------------------------------------------------------------------
// pqd_checker
// Port-level assertions on the palette quantizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "palette_quantizer_with_dither_assert.svh"

module pqd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic                           item_ready,
    input  logic                           item_cmd,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  logic [pqd_pkg::ADDR_W-1:0]     result_index,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [pqd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    input  logic [31:0]                    prdata
);

    // A pixel item occupies the block: no item right after it
    `PQD_ASSERT_NEXT(a_pixel_busy, item_valid && item_ready && (item_cmd == pqd_pkg::CMD_PIXEL), !item_ready, "item accepted right after a pixel item")

    // A load item finishes in its accept cycle
    `PQD_ASSERT_NEXT(a_load_ready, item_valid && item_ready && (item_cmd == pqd_pkg::CMD_LOAD), item_ready, "block busy after a load item")

    // A waiting result holds its value
    `PQD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_index), "stalled result changed")

    // A new result comes only from a pixel in flight
    `PQD_ASSERT(a_result_rise, $rose(result_valid) |-> $past(!item_ready), "result appeared while idle")

    // The dither register reads back what was written
    `PQD_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && pready && (paddr[pqd_pkg::CFG_ADDR_W-1:2] == pqd_pkg::CFG_IDX_DITHER), (paddr[pqd_pkg::CFG_ADDR_W-1:2] != pqd_pkg::CFG_IDX_DITHER) || (prdata[0] == $past(pwdata[0])), "dither enable readback mismatch")

endmodule

bind palette_quantizer_with_dither pqd_checker u_pqd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_cmd     (item.cmd),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_index (result.pixel_index),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

// ===== verif/palette_quantizer_with_dither_tb.sv =====
// ----------------------------------------------------------------------------
// palette_quantizer_with_dither_tb
// Self-checking bench for the dithered palette quantizer. It fills the
// palette, runs a short table of directed loads and pixels, then runs
// phases of random items with dither switched on and off and with
// different idling on both channels. A predictor in the bench tracks the
// palette, the random generator and the dither register. Every result is
// compared with the oldest predicted pixel index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_quantizer_with_dither_tb;

    localparam int          ADDR_BITS   = pqd_pkg::ADDR_W;
    localparam int          COLOR_BITS  = pqd_pkg::COLOR_W;
    localparam int          CHAN_BITS   = pqd_pkg::CHAN_W;
    localparam int          CADDR_BITS  = pqd_pkg::CFG_ADDR_W;
    localparam logic        CMD_LOAD    = pqd_pkg::CMD_LOAD;
    localparam logic        CMD_PIXEL   = pqd_pkg::CMD_PIXEL;
    localparam logic [31:0] SEED_VALUE  = 32'd1234567;
    localparam logic [31:0] MULTIPLIER  = 32'd16807;
    localparam int          NO_CHECK    = -1;
    localparam int          SETTLE_CYC  = 300;
    localparam int          PHASES      = 6;
    localparam int          PHASE_ITEMS = 96;
    localparam logic [CADDR_BITS-1:0] DITHER_ADDR =
        CADDR_BITS'(4 * pqd_pkg::CFG_IDX_DITHER);

    typedef enum logic {ROW_ITEM, ROW_DITHER} row_kind_t;
    typedef enum logic [1:0] {IDLE_SRC_LIGHT, IDLE_SNK_LIGHT, IDLE_NONE} idle_mode_t;

    typedef struct packed {
        logic                  cmd;
        logic [ADDR_BITS-1:0]  entry_index;
        logic [COLOR_BITS-1:0] entry_color;
        logic [CHAN_BITS-1:0]  red;
        logic [CHAN_BITS-1:0]  green;
        logic [CHAN_BITS-1:0]  blue;
        logic                  frame_start;
    } quant_item_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        dither;
        quant_item_t it;
        int          want;
    } dir_row_t;

    // Palette holds 0x808080 everywhere before these rows
    localparam dir_row_t DIRECTED_ROWS [20] = '{
        '{ROW_ITEM,   1'b0, '{CMD_LOAD,  8'd0,   24'h000000, 8'h00, 8'h00, 8'h00, 1'b1}, NO_CHECK},
        '{ROW_ITEM,   1'b0, '{CMD_LOAD,  8'd255, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, NO_CHECK},
        '{ROW_ITEM,   1'b0, '{CMD_LOAD,  8'd128, 24'hFF0000, 8'h00, 8'h00, 8'h00, 1'b0}, NO_CHECK},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd0,   24'h000000, 8'h00, 8'h00, 8'h00, 1'b1}, 0},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd0,   24'h000000, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 255},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd0,   24'h000000, 8'hFF, 8'h00, 8'h00, 1'b0}, 128},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd255, 24'hFFFFFF, 8'h80, 8'h80, 8'h80, 1'b0}, 1},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd7,   24'h123456, 8'h81, 8'h7F, 8'h80, 1'b0}, 1},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd0,   24'h000000, 8'h00, 8'hFF, 8'h00, 1'b0}, NO_CHECK},
        '{ROW_DITHER, 1'b1, '{CMD_LOAD,  8'd0,   24'h000000, 8'h00, 8'h00, 8'h00, 1'b0}, NO_CHECK},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd0,   24'h000000, 8'h80, 8'h80, 8'h80, 1'b1}, 1},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd0,   24'h000000, 8'h00, 8'h00, 8'h00, 1'b0}, 0},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd0,   24'h000000, 8'h40, 8'h40, 8'h40, 1'b1}, NO_CHECK},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd0,   24'h000000, 8'h40, 8'h40, 8'h40, 1'b0}, NO_CHECK},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd0,   24'h000000, 8'h60, 8'h60, 8'h60, 1'b0}, NO_CHECK},
        '{ROW_ITEM,   1'b0, '{CMD_LOAD,  8'd2,   24'h7F7F7F, 8'h00, 8'h00, 8'h00, 1'b1}, NO_CHECK},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd0,   24'h000000, 8'h7F, 8'h7F, 8'h7F, 1'b0}, NO_CHECK},
        '{ROW_DITHER, 1'b0, '{CMD_LOAD,  8'd0,   24'h000000, 8'h00, 8'h00, 8'h00, 1'b0}, NO_CHECK},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd0,   24'h000000, 8'h10, 8'h20, 8'h30, 1'b1}, NO_CHECK},
        '{ROW_ITEM,   1'b0, '{CMD_PIXEL, 8'd0,   24'h000000, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 255}
    };

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    pqd_item_if   item_bus ();
    pqd_result_if result_bus ();

    // Predictor state
    logic [COLOR_BITS-1:0] palette_copy [pqd_pkg::STORE_DEPTH];
    logic [31:0]           gen_state;
    logic                  dither_on;

    logic [ADDR_BITS-1:0]  index_queue [$];
    int                    mismatches;
    int                    src_idle_pct;
    int                    snk_idle_pct;

    palette_quantizer_with_dither uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_bus.sink),
        .result  (result_bus.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Score of one palette color: summed channel distance divided by three
    function automatic int unsigned palette_distance(
        input logic [COLOR_BITS-1:0] c,
        input logic [CHAN_BITS-1:0]  r,
        input logic [CHAN_BITS-1:0]  g,
        input logic [CHAN_BITS-1:0]  b
    );
        int unsigned dr;
        int unsigned dg;
        int unsigned db;
        dr = (c[23:16] > r) ? c[23:16] - r : r - c[23:16];
        dg = (c[15:8] > g) ? c[15:8] - g : g - c[15:8];
        db = (c[7:0] > b) ? c[7:0] - b : b - c[7:0];
        return (dr + dg + db) / 3;
    endfunction

    function automatic longint unsigned round_half_even(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned q;
        longint unsigned rem;
        q   = num / den;
        rem = num % den;
        if (2 * rem > den || (2 * rem == den && q[0]))
            q++;
        return q;
    endfunction

    // Nearest-color search with optional dither; advances the generator
    function automatic logic [ADDR_BITS-1:0] quantize_pixel(input quant_item_t it);
        int unsigned          best;
        int unsigned          d;
        int unsigned          dnear;
        int unsigned          dnext;
        logic [ADDR_BITS-1:0] nearest;
        logic [ADDR_BITS-1:0] runner;
        logic [ADDR_BITS-1:0] chosen;
        logic [31:0]          mag;
        longint unsigned      randf;
        longint unsigned      chance;
        best    = 32'hFFFF_FFFF;
        nearest = '0;
        runner  = '0;
        if (it.frame_start)
            gen_state = SEED_VALUE;
        for (int i = 0; i < pqd_pkg::PALETTE_SIZE; i++)
        begin
            d = palette_distance(palette_copy[i], it.red, it.green, it.blue);
            if (d < best)
            begin
                runner  = nearest;
                nearest = ADDR_BITS'(i);
                best    = d;
            end
        end
        chosen = nearest;
        if (dither_on)
        begin
            gen_state = gen_state * MULTIPLIER;
            // two's complement magnitude; the most negative value maps onto itself
            mag   = gen_state[31] ? (~gen_state + 32'd1) : gen_state;
            randf = round_half_even(64'(mag) * 1000, 64'h8000_0000);
            dnear = palette_distance(palette_copy[nearest], it.red, it.green, it.blue);
            dnext = palette_distance(palette_copy[runner], it.red, it.green, it.blue);
            if (dnext != 0)
            begin
                chance = round_half_even(
                    64'((dnext >= dnear) ? dnext - dnear : 0) * 1000, 64'(dnext));
                if (randf > chance)
                    chosen = runner;
            end
        end
        return chosen;
    endfunction

    // Pixel channel close to a palette channel, clamped to 8 bits
    function automatic logic [CHAN_BITS-1:0] near_channel(input logic [CHAN_BITS-1:0] c);
        int v;
        v = int'(c) + $urandom_range(0, 8) - 4;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return CHAN_BITS'(v);
    endfunction

    function automatic quant_item_t random_item();
        quant_item_t           it;
        logic [COLOR_BITS-1:0] base;
        it.entry_index = ADDR_BITS'($urandom_range(0, 255));
        it.entry_color = COLOR_BITS'($urandom);
        it.red         = CHAN_BITS'($urandom);
        it.green       = CHAN_BITS'($urandom);
        it.blue        = CHAN_BITS'($urandom);
        it.frame_start = ($urandom_range(0, 15) == 0);
        if ($urandom_range(0, 99) < 40)
        begin
            it.cmd = CMD_LOAD;
            // pin some colors to the corners of the cube
            case ($urandom_range(0, 7))
                0: it.entry_color = '0;
                1: it.entry_color = '1;
                default: ;
            endcase
        end
        else
        begin
            it.cmd = CMD_PIXEL;
            if ($urandom_range(0, 1) == 1)
            begin
                base     = palette_copy[$urandom_range(0, pqd_pkg::PALETTE_SIZE - 1)];
                it.red   = near_channel(base[23:16]);
                it.green = near_channel(base[15:8]);
                it.blue  = near_channel(base[7:0]);
            end
        end
        return it;
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SRC_LIGHT:
            begin
                src_idle_pct = 21;
                snk_idle_pct = 81;
            end
            IDLE_SNK_LIGHT:
            begin
                src_idle_pct = 81;
                snk_idle_pct = 21;
            end
            default:
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one item; entered and left on a falling edge
    task automatic send_item(input quant_item_t it, input int want);
        logic                 taken;
        logic [ADDR_BITS-1:0] predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.cmd         <= it.cmd;
        item_bus.entry_index <= it.entry_index;
        item_bus.entry_color <= it.entry_color;
        item_bus.red         <= it.red;
        item_bus.green       <= it.green;
        item_bus.blue        <= it.blue;
        item_bus.frame_start <= it.frame_start;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = item_bus.ready;
            @(negedge clk);
        end
        if (it.cmd == CMD_LOAD)
            palette_copy[it.entry_index] = it.entry_color;
        else
        begin
            predicted = quantize_pixel(it);
            index_queue.push_back((want == NO_CHECK) ? predicted : ADDR_BITS'(want));
        end
    endtask

    // Hold the sender until every expected result is back
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (index_queue.size() != 0);
    endtask

    task automatic apb_access(
        input  logic                  wr,
        input  logic [CADDR_BITS-1:0] addr,
        input  logic [31:0]           wdata,
        output logic [31:0]           rdata
    );
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Switch dither with the block idle, then read it back
    task automatic program_dither(input logic on);
        logic [31:0] rdata;
        wait_drained();
        repeat (SETTLE_CYC) @(negedge clk);
        apb_access(1'b1, DITHER_ADDR, 32'(on), rdata);
        dither_on = on;
        apb_access(1'b0, DITHER_ADDR, 32'd0, rdata);
        if (rdata !== 32'(on))
        begin
            mismatches++;
            $display("%0t: dither_enable readback expected %0h actual %0h",
                     $time, 32'(on), rdata);
        end
    endtask

    // Result ready, redrawn every cycle
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        logic [ADDR_BITS-1:0] want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (index_queue.size() == 0)
            begin
                mismatches++;
                $display("%0t: pixel_index expected none actual %0d",
                         $time, result_bus.pixel_index);
            end
            else
            begin
                want = index_queue.pop_front();
                if (result_bus.pixel_index !== want)
                begin
                    mismatches++;
                    $display("%0t: pixel_index expected %0d actual %0d",
                             $time, want, result_bus.pixel_index);
                end
            end
        end
    end

    initial
    begin : stimulus
        quant_item_t fill;
        dir_row_t    row;
        mismatches               = 0;
        gen_state                = SEED_VALUE;
        dither_on                = 1'b0;
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        item_bus.valid           = 1'b0;
        item_bus.cmd             = CMD_LOAD;
        item_bus.entry_index     = '0;
        item_bus.entry_color     = '0;
        item_bus.red             = '0;
        item_bus.green           = '0;
        item_bus.blue            = '0;
        item_bus.frame_start     = 1'b0;
        set_idling(IDLE_SRC_LIGHT);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill the whole palette so no pixel reads an unwritten slot
        fill = '{CMD_LOAD, 8'd0, 24'h808080, 8'h00, 8'h00, 8'h00, 1'b0};
        for (int i = 0; i < pqd_pkg::STORE_DEPTH; i++)
        begin
            fill.entry_index = ADDR_BITS'(i);
            send_item(fill, NO_CHECK);
        end

        // Directed table
        foreach (DIRECTED_ROWS[i])
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_DITHER)
                program_dither(row.dither);
            else
                send_item(row.it, row.want);
        end

        // Random phases: dither alternates, idling changes every two phases
        for (int p = 0; p < PHASES; p++)
        begin
            program_dither(~p[0]);
            set_idling(idle_mode_t'(p / 2));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
                send_item(random_item(), NO_CHECK);
            end
        end

        wait_drained();
        repeat (SETTLE_CYC) @(negedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pqd_pkg.sv
hdl/pqd_if.sv
hdl/pqd_ram.sv
hdl/pqd_div.sv
hdl/palette_quantizer_with_dither.sv
hdl/pqd_checker.sv
verif/palette_quantizer_with_dither_tb.sv
